### rtl/mfb_pkg.sv
// ----------------------------------------------------------------------------
// mfb_pkg
// shared constants and types for the max flow block
// ----------------------------------------------------------------------------
package mfb_pkg;

    localparam int NODE_COUNT = 8;
    localparam int NODE_BITS  = $clog2(NODE_COUNT);
    localparam int CAP_BITS   = 16;
    localparam int RES_BITS   = CAP_BITS + 1;
    localparam int FLOW_BITS  = 19;
    localparam int ADDR_BITS  = 2 * NODE_BITS;
    localparam int CELL_COUNT = NODE_COUNT * NODE_COUNT;

    // configuration register indexes
    localparam logic CFG_SOURCE = 1'b0;
    localparam logic CFG_SINK   = 1'b1;

    typedef enum logic [9:0] {
        S_LOAD  = 10'b0000000001,
        S_INIT  = 10'b0000000010,
        S_POP   = 10'b0000000100,
        S_RD    = 10'b0000001000,
        S_CHK   = 10'b0000010000,
        S_NRD   = 10'b0000100000,
        S_NCHK  = 10'b0001000000,
        S_ARD   = 10'b0010000000,
        S_AWF   = 10'b0100000000,
        S_AWR   = 10'b1000000000
    } t_state;

endpackage

### rtl/max_flow_bfs_augment.sv
// ----------------------------------------------------------------------------
// max_flow_bfs_augment
// edmonds-karp max flow over a residual matrix held in a ram
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_valid / o_stall) carries capacity entries, one transfer
//   per cycle while loading. an entry flagged last_entry starts the flow run;
//   o_stall stays high until the result transfer completes.
//   output channel (o_valid / i_stall) carries one result per graph:
//   max_flow and same_node_error. the result holds while i_stall is high.
//   the run is bound by the single read port of the residual ram: each
//   search has a setup step, a pop step per dequeued node plus a read and
//   a check step per neighbor, and a final pop; then a read and a check
//   step per path edge for the bottleneck walk and a read, a forward write
//   and a reverse write step per edge for the update, repeated once per
//   augmenting path. source equal to sink gives a result the cycle after
//   the last entry.
//   reset: source 0, sink 7, residuals read as zero, loading state.
//   after each result transfer the residuals are zero again at once
//   (per-cell valid flags are cleared).
//   config: write source (index 0) and sink (index 1) only while idle.
// ----------------------------------------------------------------------------
module max_flow_bfs_augment (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_index,
    input  logic [mfb_pkg::NODE_BITS-1:0]   i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [mfb_pkg::NODE_BITS-1:0]   i_from_node,
    input  logic [mfb_pkg::NODE_BITS-1:0]   i_to_node,
    input  logic [mfb_pkg::CAP_BITS-1:0]    i_capacity,
    input  logic                            i_last_entry,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [mfb_pkg::FLOW_BITS-1:0]   o_max_flow,
    output logic                            o_same_node_error
);

    localparam int NB = mfb_pkg::NODE_BITS;
    localparam int RB = mfb_pkg::RES_BITS;
    localparam int AB = mfb_pkg::ADDR_BITS;
    localparam int NN = mfb_pkg::NODE_COUNT;

    mfb_pkg::t_state r_state;

    logic [NB-1:0] r_src, r_snk;
    logic [mfb_pkg::CELL_COUNT-1:0] r_vld;       // cell holds a written value
    logic          r_rd_vld;
    logic [NB-1:0] r_parent [mfb_pkg::NODE_COUNT];
    logic [NB-1:0] r_queue  [mfb_pkg::NODE_COUNT];
    logic [mfb_pkg::NODE_COUNT-1:0] r_visited;
    logic [NB:0]   r_head, r_tail;
    logic [NB-1:0] r_node, r_nb, r_v;
    logic [RB-1:0] r_neck;
    logic [mfb_pkg::FLOW_BITS-1:0] r_flow;

    logic          in_acc, out_acc;
    logic          ram_we;
    logic [AB-1:0] ram_waddr, ram_raddr;
    logic [RB-1:0] ram_wdata, ram_q, rd_data;
    logic [NB-1:0] par_v;

    assign o_stall = (r_state != mfb_pkg::S_LOAD) || o_valid;
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;
    assign par_v   = r_parent[r_v];
    // cells never written read as zero
    assign rd_data = r_rd_vld ? ram_q : '0;

    // ram read address per state
    always_comb begin
        unique case (r_state)
            mfb_pkg::S_RD:  ram_raddr = {r_node, r_nb};
            mfb_pkg::S_NRD: ram_raddr = {par_v, r_v};
            mfb_pkg::S_ARD: ram_raddr = {par_v, r_v};
            mfb_pkg::S_AWF: ram_raddr = {r_v, par_v};   // reverse edge
            default:        ram_raddr = '0;
        endcase
    end

    // ram write port: loading, then forward and reverse residual update
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = {i_from_node, i_to_node};
        ram_wdata = {1'b0, i_capacity};
        unique case (r_state)
            mfb_pkg::S_LOAD: ram_we = in_acc;
            mfb_pkg::S_AWF: begin
                ram_we    = 1'b1;
                ram_waddr = {par_v, r_v};
                ram_wdata = rd_data - r_neck;
            end
            mfb_pkg::S_AWR: begin
                ram_we    = 1'b1;
                ram_waddr = {r_v, par_v};
                ram_wdata = rd_data + r_neck;
            end
            default: ram_we = 1'b0;
        endcase
    end

    mfb_ram #(
        .WIDTH (RB),
        .DEPTH (mfb_pkg::CELL_COUNT)
    ) u_res_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_vld[ram_raddr];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src <= '0;
            r_snk <= NB'(7);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mfb_pkg::CFG_SOURCE: r_src <= i_cfg_data;
                mfb_pkg::CFG_SINK:   r_snk <= i_cfg_data;
                default:             r_src <= r_src;
            endcase
        end
    end

    // main sequencer: bfs, bottleneck walk, augment
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mfb_pkg::S_LOAD;
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else begin
            if (out_acc) begin
                o_valid <= 1'b0;
                r_vld   <= '0;
            end else if (ram_we) begin
                r_vld[ram_waddr] <= 1'b1;
            end
            unique case (r_state)
                mfb_pkg::S_LOAD: begin
                    if (in_acc && i_last_entry) begin
                        r_flow <= '0;
                        if (r_src == r_snk) begin
                            o_valid           <= 1'b1;
                            o_max_flow        <= '0;
                            o_same_node_error <= 1'b1;
                        end else begin
                            r_state <= mfb_pkg::S_INIT;
                        end
                    end
                end
                mfb_pkg::S_INIT: begin
                    r_visited        <= NN'(1) << r_src;
                    r_queue[0]       <= r_src;
                    r_head           <= '0;
                    r_tail           <= (NB+1)'(1);
                    r_state          <= mfb_pkg::S_POP;
                end
                mfb_pkg::S_POP: begin
                    if (r_head < r_tail) begin
                        r_node  <= r_queue[r_head[NB-1:0]];
                        r_head  <= r_head + 1'b1;
                        r_nb    <= '0;
                        r_state <= mfb_pkg::S_RD;
                    end else if (r_visited[r_snk]) begin
                        r_v     <= r_snk;
                        r_neck  <= '1;
                        r_state <= mfb_pkg::S_NRD;
                    end else begin
                        // sink unreachable: flow is final
                        o_valid           <= 1'b1;
                        o_max_flow        <= r_flow;
                        o_same_node_error <= 1'b0;
                        r_state           <= mfb_pkg::S_LOAD;
                    end
                end
                mfb_pkg::S_RD: r_state <= mfb_pkg::S_CHK;
                mfb_pkg::S_CHK: begin
                    if (!r_visited[r_nb] && rd_data != '0 &&
                        r_tail < (NB+1)'(mfb_pkg::NODE_COUNT)) begin
                        r_queue[r_tail[NB-1:0]] <= r_nb;
                        r_parent[r_nb]          <= r_node;
                        r_visited[r_nb]         <= 1'b1;
                        r_tail                  <= r_tail + 1'b1;
                    end
                    r_nb    <= r_nb + 1'b1;
                    r_state <= (r_nb == '1) ? mfb_pkg::S_POP : mfb_pkg::S_RD;
                end
                mfb_pkg::S_NRD: r_state <= mfb_pkg::S_NCHK;
                mfb_pkg::S_NCHK: begin
                    if (rd_data < r_neck) begin
                        r_neck <= rd_data;
                    end
                    if (par_v == r_src) begin
                        r_v     <= r_snk;
                        r_state <= mfb_pkg::S_ARD;
                    end else begin
                        r_v     <= par_v;
                        r_state <= mfb_pkg::S_NRD;
                    end
                end
                mfb_pkg::S_ARD: r_state <= mfb_pkg::S_AWF;
                mfb_pkg::S_AWF: r_state <= mfb_pkg::S_AWR;
                mfb_pkg::S_AWR: begin
                    r_v <= par_v;
                    if (par_v == r_src) begin
                        r_flow  <= r_flow + mfb_pkg::FLOW_BITS'(r_neck);
                        r_state <= mfb_pkg::S_INIT;
                    end else begin
                        r_state <= mfb_pkg::S_ARD;
                    end
                end
                default: r_state <= mfb_pkg::S_LOAD;
            endcase
        end
    end

endmodule

### rtl/mfb_ram.sv
// ----------------------------------------------------------------------------
// mfb_ram
// generic simple dual port ram with registered read
// ----------------------------------------------------------------------------
module mfb_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### test/max_flow_bfs_augment_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_flow_bfs_augment_test
// self-checking bench: graphs of capacity entries are streamed in under
// random gaps and output stalls, flows are predicted in the bench and each
// result is compared with the oldest prediction
// ----------------------------------------------------------------------------
module max_flow_bfs_augment_test;

    typedef struct {
        logic [2:0]  from_node;
        logic [2:0]  to_node;
        logic [15:0] capacity;
        logic        last_entry;
    } t_entry;

    typedef struct {
        logic [18:0] max_flow;
        logic        same_node_error;
    } t_flow_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = mfb_pkg::CFG_SOURCE;
    logic [2:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_from_node = '0;
    logic [2:0]  i_to_node = '0;
    logic [15:0] i_capacity = '0;
    logic        i_last_entry = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [18:0] o_max_flow;
    logic        o_same_node_error;

    max_flow_bfs_augment u_dut (.*);

    always #4 i_clk = ~i_clk;

    t_entry       pending_entries[$];
    t_flow_result expected_flows[$];
    longint       cap_grid[mfb_pkg::CELL_COUNT];
    logic [2:0]   source_shadow = 3'd0;
    logic [2:0]   sink_shadow = 3'd7;
    int           error_count = 0;
    int           graphs_checked = 0;
    int           entries_sent = 0;
    int           cycle_count = 0;
    bit           entry_taken = 1'b0;
    bit           hold_request = 1'b0;
    bit           hold_used = 1'b0;

    // edmonds-karp on the bench copy of the residual grid
    function automatic longint solve_flow(int src, int snk);
        int     parent[mfb_pkg::NODE_COUNT];
        bit     seen[mfb_pkg::NODE_COUNT];
        int     fifo[mfb_pkg::NODE_COUNT];
        int     head;
        int     tail;
        int     u;
        int     v;
        longint neck;
        longint total;
        total = 0;
        forever begin
            foreach (seen[k]) seen[k] = 1'b0;
            head = 0;
            tail = 0;
            fifo[tail++] = src;
            seen[src] = 1'b1;
            while (head < tail) begin
                u = fifo[head++];
                for (int nb = 0; nb < mfb_pkg::NODE_COUNT; nb++) begin
                    if (!seen[nb] && cap_grid[u*mfb_pkg::NODE_COUNT+nb] > 0 &&
                        tail < mfb_pkg::NODE_COUNT) begin
                        fifo[tail++] = nb;
                        parent[nb] = u;
                        seen[nb] = 1'b1;
                    end
                end
            end
            if (!seen[snk]) break;
            neck = 64'h7fff_ffff_ffff_ffff;
            for (v = snk; v != src; v = parent[v]) begin
                u = parent[v];
                if (cap_grid[u*mfb_pkg::NODE_COUNT+v] < neck)
                    neck = cap_grid[u*mfb_pkg::NODE_COUNT+v];
            end
            for (v = snk; v != src; v = parent[v]) begin
                u = parent[v];
                cap_grid[u*mfb_pkg::NODE_COUNT+v] -= neck;
                cap_grid[v*mfb_pkg::NODE_COUNT+u] += neck;
            end
            total += neck;
        end
        return total;
    endfunction

    // input transfer: update the grid, predict on the last entry
    always @(posedge i_clk) begin
        t_flow_result r;
        entry_taken = 1'b0;
        if (i_rst_n && i_valid && !o_stall) begin
            entry_taken = 1'b1;
            entries_sent++;
            cap_grid[i_from_node*mfb_pkg::NODE_COUNT+i_to_node] = longint'(i_capacity);
            if (i_last_entry) begin
                r.same_node_error = (source_shadow == sink_shadow);
                r.max_flow = r.same_node_error ? '0 :
                    19'(solve_flow(int'(source_shadow), int'(sink_shadow)));
                expected_flows.push_back(r);
                foreach (cap_grid[k]) cap_grid[k] = 0;
            end
        end
    end

    // driver: bursts of transfers with random gaps between them
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge i_clk) begin
        t_entry e;
        if (i_rst_n && (!i_valid || entry_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_entries.size() > 0) begin
                e = pending_entries.pop_front();
                i_from_node <= e.from_node;
                i_to_node <= e.to_node;
                i_capacity <= e.capacity;
                i_last_entry <= e.last_entry;
                i_valid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end else begin
                    burst_left--;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, plus one long hold-off on request
    int stall_phase = 0;
    int hold_left = 0;
    always @(negedge i_clk) begin
        if (hold_request && !hold_used) begin
            hold_left = 400;
            hold_used = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            stall_phase = (stall_phase + 1) % 64;
            // stall-free stretch in the first quarter of each pattern
            i_stall <= (stall_phase >= 16) && ($urandom_range(0, 2) == 0);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_flow_result x;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_flows.size() == 0) begin
                $error("unexpected result max_flow=%0d same_node_error=%0b",
                       o_max_flow, o_same_node_error);
                error_count++;
            end else begin
                x = expected_flows.pop_front();
                graphs_checked++;
                if (o_max_flow !== x.max_flow) begin
                    $error("max_flow expected %0d actual %0d", x.max_flow, o_max_flow);
                    error_count++;
                end
                if (o_same_node_error !== x.same_node_error) begin
                    $error("same_node_error expected %0b actual %0b",
                           x.same_node_error, o_same_node_error);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > 3000000) begin
            $display("timeout with %0d results outstanding", expected_flows.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic add_entry(int f, int t, int c, bit last);
        t_entry e;
        e.from_node = 3'(f);
        e.to_node = 3'(t);
        e.capacity = 16'(c);
        e.last_entry = last;
        pending_entries.push_back(e);
    endtask

    task automatic write_cfg(logic idx, logic [2:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == mfb_pkg::CFG_SOURCE) source_shadow = val;
        else sink_shadow = val;
    endtask

    task automatic drain;
        while (pending_entries.size() > 0 || expected_flows.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    // random graph: mostly 4 to 14 entries between random nodes, random capacities
    task automatic add_graph();
        int n;
        int cap;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 14);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 5))
                0: cap = 16'hffff;
                1: cap = $urandom_range(0, 3);
                default: cap = $urandom_range(0, 65535);
            endcase
            add_entry($urandom_range(0, 7), $urandom_range(0, 7), cap, k == n - 1);
        end
    endtask

    initial begin
        int src;
        int snk;
        foreach (cap_grid[k]) cap_grid[k] = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part on reset config (0 to 7)
        add_entry(0, 7, 0, 1);                  // lone last entry, zero edge
        add_entry(0, 7, 100, 0);
        add_entry(0, 7, 5, 0);                  // repeated entry overwrites
        add_entry(3, 3, 16'hffff, 1);           // self loop has no effect
        for (int k = 1; k < 7; k++) begin       // widest possible flow
            add_entry(0, k, 16'hffff, 0);
            add_entry(k, 7, 16'hffff, 0);
        end
        add_entry(0, 7, 16'hffff, 1);
        add_entry(0, 1, 10, 0);                 // a later path needs the cross edge 1 to 2
        add_entry(0, 2, 10, 0);
        add_entry(1, 2, 5, 0);
        add_entry(1, 7, 4, 0);
        add_entry(2, 7, 12, 1);
        drain();

        // source equals sink, then source 7 and sink 0
        write_cfg(mfb_pkg::CFG_SOURCE, 3'd7);
        add_entry(0, 7, 50, 1);
        drain();
        write_cfg(mfb_pkg::CFG_SOURCE, 3'd7);
        write_cfg(mfb_pkg::CFG_SINK, 3'd0);
        add_entry(7, 0, 16'hffff, 0);
        add_entry(7, 3, 9, 0);
        add_entry(3, 0, 6, 1);
        drain();

        // long receiver hold-off while several graphs are waiting
        for (int g = 0; g < 4; g++) add_graph();
        hold_request = 1'b1;
        drain();

        // random phases across many source and sink settings
        while (entries_sent < 900) begin
            src = $urandom_range(0, 7);
            snk = ($urandom_range(0, 7) == 0) ? src : $urandom_range(0, 7);
            write_cfg(mfb_pkg::CFG_SOURCE, 3'(src));
            write_cfg(mfb_pkg::CFG_SINK, 3'(snk));
            for (int g = 0; g < 12; g++) add_graph();
            drain();
        end

        $display("checked %0d flow results from %0d entries over many source/sink settings",
                 graphs_checked, entries_sent);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
